@@ sv/qoi_enc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// QOI encoder package
// Shared types, chunk opcodes and the pixel hash of the QOI pixel encoder.
// ----------------------------------------------------------------------------
package qoi_enc_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int HASH_W        = $clog2(TABLE_ENTRIES);
	localparam int HASH_SUM_W    = 13;
	localparam int MAX_RUN       = 62;
	localparam int RUN_W         = 6;
	localparam int MAX_BYTES     = 6;
	localparam int CNT_W         = 3;

	localparam logic [7:0] OP_INDEX     = 8'h00;
	localparam logic [7:0] OP_DIFF      = 8'h40;
	localparam logic [7:0] OP_LUMA      = 8'h80;
	localparam logic [7:0] OP_RUN       = 8'hC0;
	localparam logic [7:0] OP_RGB       = 8'hFE;
	localparam logic [7:0] OP_RGBA      = 8'hFF;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	localparam pixel_t PIXEL_RESET = '{red: 8'h00, green: 8'h00, blue: 8'h00,
		alpha: 8'hFF};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_pixel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
		logic       image_done;
	} out_item_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] data;
		logic [CNT_W-1:0]          cnt;
	} chunk_t;

	typedef struct packed {
		logic              en;
		logic [HASH_W-1:0] addr;
		pixel_t            data;
	} tbl_wr_t;

	function automatic logic [HASH_W-1:0] pixel_hash(input pixel_t p);
		logic [HASH_SUM_W-1:0] s;
		s = HASH_SUM_W'(p.red) * HASH_SUM_W'(3) + HASH_SUM_W'(p.green) * HASH_SUM_W'(5)
			+ HASH_SUM_W'(p.blue) * HASH_SUM_W'(7) + HASH_SUM_W'(p.alpha) * HASH_SUM_W'(11);
		return s[HASH_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/qoi_enc_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// QOI seen-pixel table
// 64-entry synchronous RAM with per-entry valid bits and write-to-read
// forwarding; an invalid entry reads as an all-zero pixel.
// ----------------------------------------------------------------------------
module qoi_enc_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rd_en,
	input  wire logic [qoi_enc_pkg::HASH_W-1:0] rd_addr,
	input  wire logic [qoi_enc_pkg::HASH_W-1:0] addr_s1,
	input  wire qoi_enc_pkg::tbl_wr_t           wr,
	input  wire logic                           clear,
	output qoi_enc_pkg::pixel_t                 entry
);

	qoi_enc_pkg::pixel_t                       mem_q [qoi_enc_pkg::TABLE_ENTRIES];
	qoi_enc_pkg::pixel_t                       rdata_s1;
	qoi_enc_pkg::pixel_t                       fwd_data_s1;
	logic                                      fwd_s1;
	logic [qoi_enc_pkg::TABLE_ENTRIES-1:0]     valid_q;

	// RAM: read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1    <= mem_q[rd_addr];
			fwd_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_s1 <= wr.en && (wr.addr == rd_addr);
		end
	end

	// clear wins over a write in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_comb begin
		if (!valid_q[addr_s1]) begin
			entry = '0;
		end else if (fwd_s1) begin
			entry = fwd_data_s1;
		end else begin
			entry = rdata_s1;
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> valid_q == '0)
		else $error("table not empty after clear");

endmodule
`default_nettype wire

@@ sv/qoi_enc_chunk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// QOI chunk former
// Picks the chunk for one pixel from the previous pixel, the run count and
// the table entry, and returns its bytes plus the next state.
// ----------------------------------------------------------------------------
module qoi_enc_chunk (
	input  wire qoi_enc_pkg::pixel_t                pix,
	input  wire logic                               last,
	input  wire logic [qoi_enc_pkg::HASH_W-1:0]     hash,
	input  wire qoi_enc_pkg::pixel_t                prev,
	input  wire logic [qoi_enc_pkg::RUN_W-1:0]      run,
	input  wire qoi_enc_pkg::pixel_t                entry,
	output qoi_enc_pkg::chunk_t                     chunk,
	output qoi_enc_pkg::tbl_wr_t                    wr,
	output qoi_enc_pkg::pixel_t                     prev_next,
	output logic [qoi_enc_pkg::RUN_W-1:0]           run_next
);

	logic                                           same;
	logic [qoi_enc_pkg::RUN_W-1:0]                  run_inc;
	logic signed [7:0]                              dr;
	logic signed [7:0]                              dg;
	logic signed [7:0]                              db;
	logic signed [8:0]                              dr_dg;
	logic signed [8:0]                              db_dg;
	logic [7:0]                                     dr2;
	logic [7:0]                                     dg2;
	logic [7:0]                                     db2;
	logic [7:0]                                     dg32;
	logic [8:0]                                     rg8;
	logic [8:0]                                     bg8;
	logic                                           small_diff;
	logic                                           luma_fit;
	logic [qoi_enc_pkg::MAX_BYTES-1:0][7:0]         body;
	logic [qoi_enc_pkg::CNT_W-1:0]                  body_n;
	logic                                           run_flush;
	logic [7:0]                                     run_byte;

	always_comb begin
		same    = pix == prev;
		run_inc = run + qoi_enc_pkg::RUN_W'(1);

		dr    = $signed(pix.red - prev.red);
		dg    = $signed(pix.green - prev.green);
		db    = $signed(pix.blue - prev.blue);
		dr_dg = $signed({dr[7], dr}) - $signed({dg[7], dg});
		db_dg = $signed({db[7], db}) - $signed({dg[7], dg});
		dr2   = pix.red - prev.red + 8'd2;
		dg2   = pix.green - prev.green + 8'd2;
		db2   = pix.blue - prev.blue + 8'd2;
		dg32  = pix.green - prev.green + 8'd32;
		rg8   = dr_dg + 9'sd8;
		bg8   = db_dg + 9'sd8;

		small_diff = dr >= -8'sd2 && dr <= 8'sd1 && dg >= -8'sd2 && dg <= 8'sd1
			&& db >= -8'sd2 && db <= 8'sd1;
		luma_fit   = dg >= -8'sd32 && dg <= 8'sd31 && dr_dg >= -9'sd8 && dr_dg <= 9'sd7
			&& db_dg >= -9'sd8 && db_dg <= 9'sd7;

		body      = '0;
		body_n    = '0;
		wr.en     = 1'b0;
		wr.addr   = hash;
		wr.data   = pix;
		prev_next = prev;
		run_next  = run;

		if (same) begin
			// repeat of previous pixel: grow the run, flush at the cap or at the end
			run_flush = run_inc >= qoi_enc_pkg::RUN_W'(qoi_enc_pkg::MAX_RUN) || last;
			run_byte  = qoi_enc_pkg::OP_RUN | {2'b00, run};
			run_next  = run_flush ? '0 : run_inc;
		end else begin
			run_flush = run != '0;
			run_byte  = qoi_enc_pkg::OP_RUN | {2'b00, run - qoi_enc_pkg::RUN_W'(1)};
			run_next  = '0;
			prev_next = pix;
			if (entry == pix) begin
				body[0] = qoi_enc_pkg::OP_INDEX | {2'b00, hash};
				body_n  = qoi_enc_pkg::CNT_W'(1);
			end else begin
				wr.en = 1'b1;
				if (pix.alpha == prev.alpha) begin
					if (small_diff) begin
						body[0] = qoi_enc_pkg::OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
						body_n  = qoi_enc_pkg::CNT_W'(1);
					end else if (luma_fit) begin
						body[0] = qoi_enc_pkg::OP_LUMA | {2'b00, dg32[5:0]};
						body[1] = {rg8[3:0], bg8[3:0]};
						body_n  = qoi_enc_pkg::CNT_W'(2);
					end else begin
						body[0] = qoi_enc_pkg::OP_RGB;
						body[1] = pix.red;
						body[2] = pix.green;
						body[3] = pix.blue;
						body_n  = qoi_enc_pkg::CNT_W'(4);
					end
				end else begin
					body[0] = qoi_enc_pkg::OP_RGBA;
					body[1] = pix.red;
					body[2] = pix.green;
					body[3] = pix.blue;
					body[4] = pix.alpha;
					body_n  = qoi_enc_pkg::CNT_W'(5);
				end
			end
		end

		// prepend the run byte when a pending run is flushed
		chunk.data[0] = run_flush ? run_byte : body[0];
		for (int i = 1; i < qoi_enc_pkg::MAX_BYTES; i++) begin
			chunk.data[i] = run_flush ? body[i-1] : body[i];
		end
		chunk.cnt = body_n + qoi_enc_pkg::CNT_W'(run_flush);
	end

endmodule
`default_nettype wire

@@ sv/qoi_enc_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// QOI byte emitter
// Holds one chunk of up to six bytes and hands them out one item per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module qoi_enc_emit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire qoi_enc_pkg::chunk_t  chunk,
	input  wire logic                 load_last,
	output logic                      free,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output qoi_enc_pkg::out_item_t    out_item
);

	logic [qoi_enc_pkg::MAX_BYTES-1:0][7:0] buf_q;
	logic [qoi_enc_pkg::CNT_W-1:0]          cnt_q;
	logic [qoi_enc_pkg::CNT_W-1:0]          idx_q;
	logic                                   done_q;
	logic                                   valid_q;
	logic                                   last_b;

	always_comb begin
		last_b                = idx_q == cnt_q - qoi_enc_pkg::CNT_W'(1);
		free                  = !valid_q || (!out_stall && last_b);
		out_valid             = valid_q;
		out_item.out_byte     = buf_q[idx_q];
		out_item.last_of_item = last_b;
		out_item.image_done   = last_b && done_q;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= chunk.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= chunk.cnt;
			idx_q   <= '0;
			done_q  <= load_last;
		end else if (valid_q && !out_stall) begin
			// advance to the next byte, drop the chunk after its last one
			if (last_b) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + qoi_enc_pkg::CNT_W'(1);
			end
		end
	end

	a_idx_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cnt_q != '0) && (idx_q < cnt_q))
		else $error("byte index outside chunk");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free && (chunk.cnt != '0))
		else $error("chunk loaded over pending bytes");

endmodule
`default_nettype wire

@@ sv/qoi_pixel_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// QOI pixel encoder
// Turns a stream of RGBA pixels into QOI chunk bytes (no header, no end mark).
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry one pixel per item; last_pixel marks the
//   final pixel of an image. out_valid/out_stall/out_item carry one chunk
//   byte per item; last_of_item flags the last byte a pixel caused and
//   image_done the last byte of the image.
//   cfg_write/cfg_data set alpha_enabled (reset 1); write it only while idle.
//   An accepted pixel is registered together with its table read; its
//   chunk is then formed and loaded into the emitter once that is free.
//   Throughput: one pixel per cycle while each pixel yields at most one
//   byte and the output is not stalled; a chunk of more than one byte holds
//   the single output register until its last byte is taken. Pixels that
//   only extend a run yield no byte and pass at one per cycle.
//   Reset clears the previous pixel, run count and table valid bits at once;
//   no clearing pass is needed. The same happens after the last pixel.
//   A stalled output holds its byte; the stall backs up through the chunk
//   stage into in_stall.
// ----------------------------------------------------------------------------
module qoi_pixel_encoder (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic                   cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire qoi_enc_pkg::in_item_t  in_item,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output qoi_enc_pkg::out_item_t      out_item
);

	logic                               alpha_en_q;
	qoi_enc_pkg::pixel_t                px_in;
	logic [qoi_enc_pkg::HASH_W-1:0]     hash_in;
	logic                               accept;

	logic                               v_s1;
	qoi_enc_pkg::pixel_t                pix_s1;
	logic                               last_s1;
	logic [qoi_enc_pkg::HASH_W-1:0]     hash_s1;

	qoi_enc_pkg::pixel_t                prev_q;
	logic [qoi_enc_pkg::RUN_W-1:0]      run_q;

	qoi_enc_pkg::pixel_t                entry;
	qoi_enc_pkg::chunk_t                chunk;
	qoi_enc_pkg::tbl_wr_t               wr_raw;
	qoi_enc_pkg::tbl_wr_t               wr;
	qoi_enc_pkg::pixel_t                prev_next;
	logic [qoi_enc_pkg::RUN_W-1:0]      run_next;
	logic                               emit_free;
	logic                               adv;
	logic                               load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_en_q <= 1'b1;
		end else if (cfg_write) begin
			alpha_en_q <= cfg_data;
		end
	end

	always_comb begin
		px_in.red   = in_item.red;
		px_in.green = in_item.green;
		px_in.blue  = in_item.blue;
		px_in.alpha = alpha_en_q ? in_item.alpha : qoi_enc_pkg::ALPHA_OPAQUE;
		hash_in     = qoi_enc_pkg::pixel_hash(px_in);

		adv      = v_s1 && ((chunk.cnt == '0) || emit_free);
		load     = adv && (chunk.cnt != '0);
		in_stall = v_s1 && !adv;
		accept   = in_valid && !in_stall;

		wr       = wr_raw;
		wr.en    = wr_raw.en && adv;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= px_in;
			last_s1 <= in_item.last_pixel;
			hash_s1 <= hash_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// commit state when the pixel leaves the chunk stage; reset after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= qoi_enc_pkg::PIXEL_RESET;
			run_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				prev_q <= qoi_enc_pkg::PIXEL_RESET;
				run_q  <= '0;
			end else begin
				prev_q <= prev_next;
				run_q  <= run_next;
			end
		end
	end

	qoi_enc_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (hash_in),
		.addr_s1 (hash_s1),
		.wr      (wr),
		.clear   (adv && last_s1),
		.entry   (entry)
	);

	qoi_enc_chunk u_chunk (
		.pix       (pix_s1),
		.last      (last_s1),
		.hash      (hash_s1),
		.prev      (prev_q),
		.run       (run_q),
		.entry     (entry),
		.chunk     (chunk),
		.wr        (wr_raw),
		.prev_next (prev_next),
		.run_next  (run_next)
	);

	qoi_enc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.chunk     (chunk),
		.load_last (last_s1),
		.free      (emit_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_last_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && last_s1 |-> chunk.cnt != '0)
		else $error("last pixel produced no byte");

endmodule
`default_nettype wire

@@ bench/qoi_pixel_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// QOI pixel encoder testbench
// Sends pixel images through the encoder with random sender gaps and random
// receiver stalls. An in-bench encoder works out the chunk bytes each pixel
// must produce. Every output byte is checked against them in order. The
// alpha mode is switched between phases while the encoder is idle.
// ----------------------------------------------------------------------------
module qoi_pixel_encoder_tb;
	import qoi_enc_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RECENT_DEPTH  = 8;

	typedef enum int {
		GEN_REPEAT, GEN_DIFF, GEN_LUMA, GEN_RECALL, GEN_RGB, GEN_ALPHA, GEN_NOISE
	} pixel_kind_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_write;
	logic      cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	qoi_pixel_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// encoder state as the bench sees it
	logic      alpha_on;
	pixel_t    prev_px;
	pixel_t    seen_px [TABLE_ENTRIES];
	int        run_len;
	out_item_t chunk_bytes_due[$];

	// stimulus side
	in_item_t  pixel_queue[$];
	pixel_t    gen_prev;
	pixel_t    recent_px[$];
	int        pixels_queued;
	int        pixels_taken;
	int        mismatches;
	int        quiet_cycles;
	int        burst_left;
	int        gap_left;
	int        stall_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void forget_image();
		prev_px = PIXEL_RESET;
		foreach (seen_px[i])
			seen_px[i] = '0;
		run_len = 0;
	endfunction

	function automatic int wrapped_delta(input logic [7:0] now, input logic [7:0] was);
		logic [7:0] d;
		d = now - was;
		return int'($signed(d));
	endfunction

	function automatic void encode_pixel(input in_item_t it);
		pixel_t     px;
		int         slot;
		int         dr;
		int         dg;
		int         db;
		logic [7:0] bytes[$];
		out_item_t  ob;
		px.red   = it.red;
		px.green = it.green;
		px.blue  = it.blue;
		px.alpha = alpha_on ? it.alpha : ALPHA_OPAQUE;
		if (px == prev_px) begin
			run_len++;
			if (run_len >= MAX_RUN || it.last_pixel) begin
				bytes.push_back(OP_RUN | 8'(run_len - 1));
				run_len = 0;
			end
		end else begin
			if (run_len > 0) begin
				bytes.push_back(OP_RUN | 8'(run_len - 1));
				run_len = 0;
			end
			slot = (int'(px.red) * 3 + int'(px.green) * 5 + int'(px.blue) * 7
				+ int'(px.alpha) * 11) % TABLE_ENTRIES;
			if (seen_px[slot] == px) begin
				bytes.push_back(OP_INDEX | 8'(slot));
			end else begin
				seen_px[slot] = px;
				if (px.alpha == prev_px.alpha) begin
					dr = wrapped_delta(px.red, prev_px.red);
					dg = wrapped_delta(px.green, prev_px.green);
					db = wrapped_delta(px.blue, prev_px.blue);
					if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
						bytes.push_back(OP_DIFF | 8'(((dr + 2) << 4) | ((dg + 2) << 2) | (db + 2)));
					end else if (dg >= -32 && dg <= 31 && dr - dg >= -8 && dr - dg <= 7
							&& db - dg >= -8 && db - dg <= 7) begin
						bytes.push_back(OP_LUMA | 8'(dg + 32));
						bytes.push_back(8'(((dr - dg + 8) << 4) | (db - dg + 8)));
					end else begin
						bytes.push_back(OP_RGB);
						bytes.push_back(px.red);
						bytes.push_back(px.green);
						bytes.push_back(px.blue);
					end
				end else begin
					bytes.push_back(OP_RGBA);
					bytes.push_back(px.red);
					bytes.push_back(px.green);
					bytes.push_back(px.blue);
					bytes.push_back(px.alpha);
				end
			end
			prev_px = px;
		end
		foreach (bytes[i]) begin
			ob.out_byte     = bytes[i];
			ob.last_of_item = (i == bytes.size() - 1);
			ob.image_done   = ob.last_of_item && it.last_pixel;
			chunk_bytes_due.push_back(ob);
		end
		if (it.last_pixel)
			forget_image();
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0h, want %0h", what, got, want);
		mismatches++;
	endtask

	task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a, input bit last);
		in_item_t it;
		it.red        = r;
		it.green      = g;
		it.blue       = b;
		it.alpha      = a;
		it.last_pixel = last;
		pixel_queue.push_back(it);
		pixels_queued++;
		if (last) begin
			gen_prev = PIXEL_RESET;
		end else begin
			gen_prev = '{red: r, green: g, blue: b, alpha: a};
		end
	endtask

	// half random, half the channel extremes 00 and FF
	function automatic logic [7:0] edgy_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_image(input int unsigned len);
		int unsigned made;
		int unsigned reps;
		int          dg;
		pixel_t      p;
		pixel_kind_t kind;
		in_item_t    tail_item;
		made = 0;
		while (made < len) begin
			kind = pixel_kind_t'($urandom_range(0, 6));
			p    = gen_prev;
			reps = 1;
			case (kind)
				GEN_REPEAT: begin
					reps = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 66)
						: $urandom_range(1, 5);
				end
				GEN_DIFF: begin
					p.red   = 8'(p.red + $urandom_range(0, 3) - 2);
					p.green = 8'(p.green + $urandom_range(0, 3) - 2);
					p.blue  = 8'(p.blue + $urandom_range(0, 3) - 2);
				end
				GEN_LUMA: begin
					dg      = int'($urandom_range(0, 63)) - 32;
					p.green = 8'(int'(p.green) + dg);
					p.red   = 8'(int'(p.red) + dg + int'($urandom_range(0, 15)) - 8);
					p.blue  = 8'(int'(p.blue) + dg + int'($urandom_range(0, 15)) - 8);
				end
				GEN_RECALL: begin
					if (recent_px.size() > 0)
						p = recent_px[$urandom_range(0, recent_px.size() - 1)];
				end
				GEN_RGB: begin
					p.red   = 8'($urandom);
					p.green = 8'($urandom);
					p.blue  = 8'($urandom);
				end
				GEN_ALPHA: begin
					p.red   = 8'($urandom);
					p.green = 8'($urandom);
					p.blue  = 8'($urandom);
					p.alpha = 8'($urandom);
				end
				default: begin
					p.red   = edgy_byte();
					p.green = edgy_byte();
					p.blue  = edgy_byte();
					p.alpha = edgy_byte();
				end
			endcase
			repeat (reps)
				queue_pixel(p.red, p.green, p.blue, p.alpha, 1'b0);
			made += reps;
			if (kind != GEN_REPEAT) begin
				recent_px.push_back(p);
				if (recent_px.size() > RECENT_DEPTH)
					void'(recent_px.pop_front());
			end
		end
		// mark the final pixel of the image
		tail_item = pixel_queue.pop_back();
		tail_item.last_pixel = 1'b1;
		pixel_queue.push_back(tail_item);
		gen_prev = PIXEL_RESET;
		recent_px.delete();
	endtask

	task automatic queue_images_until(input int target);
		while (pixels_queued < target)
			queue_image(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(4, 40));
	endtask

	task automatic drain();
		while (pixels_taken != pixels_queued || chunk_bytes_due.size() != 0)
			@(posedge clk);
		// a pixel that only extends a run leaves no byte to wait for
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_alpha_mode(input logic on);
		drain();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= on;
		@(posedge clk);
		cfg_write <= 1'b0;
		alpha_on = on;
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0 || pixel_queue.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				in_valid <= 1'b1;
				in_item  <= pixel_queue.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// receiver: free stretches, short stalls, long stalls and flicker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					out_stall  <= 1'b0;
					stall_hold = $urandom_range(0, 15);
				end
				5, 6, 7: begin
					out_stall  <= 1'b1;
					stall_hold = $urandom_range(0, 3);
				end
				8: begin
					out_stall  <= 1'b1;
					stall_hold = $urandom_range(4, 20);
				end
				default: begin
					out_stall  <= 1'($urandom_range(0, 1));
					stall_hold = 0;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			encode_pixel(in_item);
			pixels_taken++;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (chunk_bytes_due.size() == 0) begin
				report_mismatch("unexpected byte", out_item.out_byte, 0);
			end else begin
				want = chunk_bytes_due.pop_front();
				if (out_item.out_byte !== want.out_byte)
					report_mismatch("out_byte", out_item.out_byte, want.out_byte);
				if (out_item.last_of_item !== want.last_of_item)
					report_mismatch("last_of_item", out_item.last_of_item, want.last_of_item);
				if (out_item.image_done !== want.image_done)
					report_mismatch("image_done", out_item.image_done, want.image_done);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_data      = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		out_stall     = 1'b0;
		alpha_on      = 1'b1;
		gen_prev      = PIXEL_RESET;
		pixels_queued = 0;
		pixels_taken  = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		burst_left    = 0;
		gap_left      = 0;
		stall_hold    = 0;
		forget_image();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// repeat of the reset pixel, then wrapped small deltas
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
		queue_pixel(8'd1, 8'd0, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd254, 8'd0, 8'd255, 1'b0);
		// luma at both ends of its ranges, then an RGB chunk
		queue_pixel(8'd216, 8'd222, 8'd231, 8'd255, 1'b0);
		queue_pixel(8'd254, 8'd253, 8'd254, 8'd255, 1'b0);
		queue_pixel(8'd128, 8'd16, 8'd240, 8'd255, 1'b0);
		// table hits: an earlier pixel, and all-zero against the cleared table
		queue_pixel(8'd1, 8'd0, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd18, 8'd52, 8'd86, 8'd120, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		// pending run flushed ahead of an alpha chunk on the last pixel
		queue_pixel(8'd7, 8'd9, 8'd11, 8'd0, 1'b1);
		// one-pixel images right after the state clears
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);

		queue_images_until(110);
		// leave a run open across the mode change
		queue_pixel(8'd10, 8'd20, 8'd30, 8'd255, 1'b0);
		queue_pixel(8'd10, 8'd20, 8'd30, 8'd255, 1'b0);
		queue_pixel(8'd10, 8'd20, 8'd30, 8'd255, 1'b0);
		set_alpha_mode(1'b0);
		queue_pixel(8'd10, 8'd20, 8'd30, 8'd77, 1'b0);
		queue_pixel(8'd11, 8'd20, 8'd30, 8'd3, 1'b1);
		queue_images_until(210);
		set_alpha_mode(1'b1);
		queue_images_until(310);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/qoi_enc_pkg.sv
sv/qoi_enc_table.sv
sv/qoi_enc_chunk.sv
sv/qoi_enc_emit.sv
sv/qoi_pixel_encoder.sv
bench/qoi_pixel_encoder_tb.sv
